// ===== rtl/mpsa_pkg.sv =====
// ----------------------------------------------------------------------------
// mpsa_pkg
// Shared widths, codes, reset sizes and helpers of the multi-pool slot
// allocator.
// ----------------------------------------------------------------------------
package mpsa_pkg;

  localparam int OpW      = 3;
  localparam int PoolW    = 3;
  localparam int SlotW    = 5;
  localparam int SizeW    = 6;
  localparam int StatusW  = 2;
  localparam int CfgIdxW  = 3;
  localparam int MapW     = 32;

  localparam int NumRegs     = 6;
  localparam int NumPoolsDef = 6;
  localparam int MaxSlotsDef = 32;

  localparam logic [SizeW-1:0] ResetSizes [NumRegs] = '{
    6'd6, 6'd4, 6'd2, 6'd6, 6'd2, 6'd1
  };
  // pools without a size register
  localparam logic [SizeW-1:0] FixedSize = 6'd1;

  typedef enum logic [OpW-1:0] {
    OpAcqAny  = 3'd0,
    OpAcqSlot = 3'd1,
    OpRelease = 3'd2,
    OpRelAll  = 3'd3,
    OpQuery   = 3'd4
  } op_e;

  typedef enum logic [StatusW-1:0] {
    StOk      = 2'd0,
    StFull    = 2'd1,
    StBusy    = 2'd2,
    StBadPool = 2'd3
  } status_e;

  typedef struct packed {
    status_e           status;
    logic [SlotW-1:0]  granted;
    logic [SizeW-1:0]  used;
    logic              any_free;
    logic [MapW-1:0]   map;
  } res_t;

  // bits below the effective size
  function automatic logic [MapW-1:0] size_mask(input logic [SizeW-1:0] size);
    logic [MapW-1:0] m;
    for (int i = 0; i < MapW; i++) begin
      m[i] = (SizeW'(i) < size);
    end
    return m;
  endfunction

endpackage

// ===== rtl/mpsa_ram.sv =====
// ----------------------------------------------------------------------------
// mpsa_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module mpsa_ram #(
  parameter int Width = 32,
  parameter int Depth = 6,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [AddrW-1:0]         waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [AddrW-1:0]         raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/mpsa_exec.sv =====
// ----------------------------------------------------------------------------
// mpsa_exec
// Operation unit: first-free search, named grant, release, release of all
// slots and popcount on one pool map; a query only reports.
// ----------------------------------------------------------------------------
module mpsa_exec (
  input  logic [mpsa_pkg::OpW-1:0]   op_i,
  input  logic [mpsa_pkg::SlotW-1:0] slot_i,
  input  logic [mpsa_pkg::SizeW-1:0] size_i,
  input  logic [mpsa_pkg::MapW-1:0]  map_i,
  output mpsa_pkg::res_t             res_o
);

  // two-level count: groups of eight, then the group sums
  function automatic logic [mpsa_pkg::SizeW-1:0] popcount(
    input logic [mpsa_pkg::MapW-1:0] v
  );
    logic [3:0]                  grp [4];
    logic [mpsa_pkg::SizeW-1:0] sum;
    for (int g = 0; g < 4; g++) begin
      grp[g] = '0;
      for (int b = 0; b < 8; b++) begin
        grp[g] = grp[g] + 4'(v[g*8+b]);
      end
    end
    sum = 6'(grp[0]) + 6'(grp[1]) + 6'(grp[2]) + 6'(grp[3]);
    return sum;
  endfunction

  logic [mpsa_pkg::MapW-1:0]  full;
  logic [mpsa_pkg::MapW-1:0]  cur;
  logic [mpsa_pkg::MapW-1:0]  free;
  logic [mpsa_pkg::MapW-1:0]  nxt;
  logic [mpsa_pkg::SlotW-1:0] first_free;
  logic                       is_full;
  logic                       slot_out;
  logic [mpsa_pkg::SizeW-1:0] used;
  mpsa_pkg::status_e          status;
  logic [mpsa_pkg::SlotW-1:0] granted;

  assign full     = mpsa_pkg::size_mask(size_i);
  assign cur      = map_i & full;
  assign free     = ~cur & full;
  assign is_full  = (cur == full);
  assign slot_out = ({1'b0, slot_i} >= size_i);

  always_comb begin
    first_free = '0;
    for (int i = mpsa_pkg::MapW - 1; i >= 0; i--) begin
      if (free[i]) begin
        first_free = mpsa_pkg::SlotW'(i);
      end
    end
  end

  always_comb begin
    status  = mpsa_pkg::StOk;
    granted = '0;
    nxt     = cur;
    case (op_i)
      mpsa_pkg::OpAcqAny: begin
        if (is_full) begin
          status = mpsa_pkg::StFull;
        end else begin
          nxt[first_free] = 1'b1;
          granted         = first_free;
        end
      end
      mpsa_pkg::OpAcqSlot: begin
        // full is reported ahead of range and busy
        if (is_full) begin
          status = mpsa_pkg::StFull;
        end else if (slot_out || cur[slot_i]) begin
          status = mpsa_pkg::StBusy;
        end else begin
          nxt[slot_i] = 1'b1;
          granted     = slot_i;
        end
      end
      mpsa_pkg::OpRelease: begin
        if (slot_out) begin
          status = mpsa_pkg::StBusy;
        end else begin
          nxt[slot_i] = 1'b0;
        end
      end
      mpsa_pkg::OpRelAll: begin
        nxt = '0;
      end
      default: begin
        // query and unused codes only report
      end
    endcase
  end

  assign used = popcount(nxt);

  assign res_o.status   = status;
  assign res_o.granted  = granted;
  assign res_o.used     = used;
  assign res_o.any_free = (used < size_i);
  assign res_o.map      = nxt;

endmodule

// ===== rtl/multi_pool_slot_allocator.sv =====
// ----------------------------------------------------------------------------
// multi_pool_slot_allocator
// Bitmap slot allocator over several pools; the pool maps live in one RAM.
// ----------------------------------------------------------------------------
// an accepted word is registered with its pool map read, then computed into
//   the output register once that is not stalled; no new word is taken until
//   the read-modify-write of the pool map through the single RAM (read, then
//   compute and write back) is done; a size write reads, trims and writes back
// reset: sizes return to their defaults, every pool map reads as all free
//   through per-pool valid flags, the output register empties
module multi_pool_slot_allocator #(
  parameter int NUM_POOLS  = mpsa_pkg::NumPoolsDef,
  parameter int SLOT_LIMIT = mpsa_pkg::MaxSlotsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // request channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [mpsa_pkg::OpW-1:0]     operation_i,
  input  logic [mpsa_pkg::PoolW-1:0]   pool_i,
  input  logic [mpsa_pkg::SlotW-1:0]   slot_i,
  // result channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [mpsa_pkg::StatusW-1:0] status_o,
  output logic [mpsa_pkg::SlotW-1:0]   granted_slot_o,
  output logic [mpsa_pkg::SizeW-1:0]   pool_size_o,
  output logic [mpsa_pkg::SizeW-1:0]   in_use_count_o,
  output logic                         any_free_o,
  // configuration channel
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [mpsa_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [mpsa_pkg::SizeW-1:0]   cfg_data_i
);

  localparam int AddrW = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;

  typedef enum logic [2:0] {
    StIdle  = 3'b001,
    StExec  = 3'b010,
    StCfgWr = 3'b100
  } state_e;

  state_e                       state_q, state_d;
  logic [AddrW-1:0]             addr_q;
  logic                         pool_bad_q;
  logic [mpsa_pkg::OpW-1:0]     op_q;
  logic [mpsa_pkg::SlotW-1:0]   slot_q;
  logic [NUM_POOLS-1:0]         valid_q;
  logic [mpsa_pkg::SizeW-1:0]   size_q [NUM_POOLS];

  logic                         out_valid_q, out_valid_d;
  logic [mpsa_pkg::StatusW-1:0] status_q, status_d;
  logic [mpsa_pkg::SlotW-1:0]   granted_q, granted_d;
  logic [mpsa_pkg::SizeW-1:0]   total_q, total_d;
  logic [mpsa_pkg::SizeW-1:0]   used_q, used_d;
  logic                         any_free_q, any_free_d;

  logic                         in_acc;
  logic                         pool_ok;
  logic                         cfg_wr;
  logic                         cfg_ok;
  logic                         exec_go;
  logic                         ram_we;
  logic                         ram_re;
  logic [AddrW-1:0]             ram_raddr;
  logic [SLOT_LIMIT-1:0]        ram_wdata;
  logic [SLOT_LIMIT-1:0]        ram_rdata;
  logic [mpsa_pkg::MapW-1:0]    map_rd;
  logic [mpsa_pkg::MapW-1:0]    map_wr;
  logic [mpsa_pkg::SizeW-1:0]   size_sel;
  logic [mpsa_pkg::SizeW-1:0]   size_eff;
  mpsa_pkg::res_t               res;

  // config wins a tie with a request
  assign cfg_ready_o = (state_q == StIdle);
  assign in_stall_o  = (state_q != StIdle) || cfg_valid_i;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;
  assign cfg_ok      = cfg_wr && (int'(cfg_index_i) < mpsa_pkg::NumRegs)
                              && (int'(cfg_index_i) < NUM_POOLS);
  assign pool_ok     = (int'(pool_i) < NUM_POOLS);

  // size registers; pools past the register list keep a fixed size
  for (genvar p = 0; p < NUM_POOLS; p++) begin : g_size
    if (p < mpsa_pkg::NumRegs) begin : g_reg
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          size_q[p] <= mpsa_pkg::ResetSizes[p];
        end else if (cfg_wr && (int'(cfg_index_i) == p)) begin
          size_q[p] <= cfg_data_i;
        end
      end
    end else begin : g_fix
      assign size_q[p] = mpsa_pkg::FixedSize;
    end
  end

  assign size_sel = size_q[addr_q];
  assign size_eff = (int'(size_sel) > SLOT_LIMIT) ? mpsa_pkg::SizeW'(SLOT_LIMIT) : size_sel;

  // map storage
  assign ram_re    = (in_acc && pool_ok) || cfg_ok;
  assign ram_raddr = cfg_ok ? AddrW'(cfg_index_i) : AddrW'(pool_i);

  mpsa_ram #(
    .Width (SLOT_LIMIT),
    .Depth (NUM_POOLS),
    .AddrW (AddrW)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (addr_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // a pool never written reads as all free
  assign map_rd = valid_q[addr_q] ? mpsa_pkg::MapW'(ram_rdata) : '0;

  mpsa_exec u_exec (
    .op_i   (op_q),
    .slot_i (slot_q),
    .size_i (size_eff),
    .map_i  (map_rd),
    .res_o  (res)
  );

  assign exec_go   = (state_q == StExec) && (!out_valid_q || !out_stall_i);
  assign ram_we    = (exec_go && !pool_bad_q) || (state_q == StCfgWr);
  assign map_wr    = (state_q == StCfgWr) ? (map_rd & mpsa_pkg::size_mask(size_eff))
                                          : res.map;
  assign ram_wdata = map_wr[SLOT_LIMIT-1:0];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (cfg_ok) begin
          state_d = StCfgWr;
        end else if (in_acc) begin
          state_d = StExec;
        end
      end
      StExec: begin
        if (exec_go) begin
          state_d = StIdle;
        end
      end
      StCfgWr: begin
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    status_d    = status_q;
    granted_d   = granted_q;
    total_d     = total_q;
    used_d      = used_q;
    any_free_d  = any_free_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (exec_go) begin
      out_valid_d = 1'b1;
      if (pool_bad_q) begin
        status_d   = mpsa_pkg::StBadPool;
        granted_d  = '0;
        total_d    = '0;
        used_d     = '0;
        any_free_d = 1'b0;
      end else begin
        status_d   = res.status;
        granted_d  = res.granted;
        total_d    = size_eff;
        used_d     = res.used;
        any_free_d = res.any_free;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      valid_q     <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (ram_we) begin
        valid_q[addr_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cfg_ok) begin
      addr_q <= AddrW'(cfg_index_i);
    end else if (in_acc) begin
      addr_q     <= pool_ok ? AddrW'(pool_i) : '0;
      pool_bad_q <= !pool_ok;
      op_q       <= operation_i;
      slot_q     <= slot_i;
    end
    status_q   <= status_d;
    granted_q  <= granted_d;
    total_q    <= total_d;
    used_q     <= used_d;
    any_free_q <= any_free_d;
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign granted_slot_o = granted_q;
  assign pool_size_o    = total_q;
  assign in_use_count_o = used_q;
  assign any_free_o     = any_free_q;

endmodule

// ===== rtl/mpsa_checker.sv =====
// ----------------------------------------------------------------------------
// mpsa_checker
// Port-level checks of the multi-pool slot allocator, bound to the top level.
// ----------------------------------------------------------------------------
module mpsa_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [mpsa_pkg::StatusW-1:0] status_o,
  input logic [mpsa_pkg::SlotW-1:0]   granted_slot_o,
  input logic [mpsa_pkg::SizeW-1:0]   pool_size_o,
  input logic [mpsa_pkg::SizeW-1:0]   in_use_count_o,
  input logic                         any_free_o
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o)
      && $stable(granted_slot_o) && $stable(pool_size_o)
      && $stable(in_use_count_o) && $stable(any_free_o))
    else $error("result word changed under stall");

  // one word in flight: the next cycle never accepts
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted while one is in flight");

  a_free_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> any_free_o == (in_use_count_o < pool_size_o))
    else $error("free flag disagrees with counts");

  a_bad_pool: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == mpsa_pkg::StBadPool |-> granted_slot_o == '0
      && pool_size_o == '0 && in_use_count_o == '0)
    else $error("invalid pool result carries data");

  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == mpsa_pkg::StFull |-> !any_free_o
      && granted_slot_o == '0 && in_use_count_o == pool_size_o)
    else $error("full result inconsistent");

endmodule

bind multi_pool_slot_allocator mpsa_checker u_mpsa_checker (.*);
